// ===== hw/rtl/hns_pkg.sv =====
package hns_pkg;

    // Field and register widths
    localparam int GW_W     = 11;
    localparam int GH_W     = 13;
    localparam int SCALE_W  = 16;
    localparam int SAMPLE_W = 8;
    localparam int NRM_W    = 26;
    localparam int NY_W     = 11;
    localparam int OCOL_W   = 10;
    localparam int OROW_W   = 12;
    localparam int PADDR_W  = 4;
    localparam int PDATA_W  = 32;

    // Register indexes (paddr[3:2])
    localparam logic [1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [1:0] REG_GRID_HEIGHT = 2'd1;
    localparam logic [1:0] REG_INV_SCALE   = 2'd2;

    // Register reset values
    localparam logic [GW_W-1:0]    GW_RESET    = 11'd256;
    localparam logic [GH_W-1:0]    GH_RESET    = 13'd256;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd256;

    // Y component of the normal, Q.8
    localparam logic [NY_W-1:0] NY_INTERIOR = 11'd1024;
    localparam logic [NY_W-1:0] NY_BORDER   = 11'd256;

    // Clamped frame geometry and height scale
    typedef struct packed {
        logic [GW_W-1:0]    w;
        logic [GW_W-1:0]    w_m1;
        logic [GH_W-1:0]    h;
        logic [GH_W-1:0]    h_m1;
        logic [SCALE_W-1:0] scale;
    } t_geom;

    // One accepted sample on its way to the result register
    typedef struct packed {
        logic                valid;
        logic                has_out;
        logic                interior;
        logic                last_row;
        logic [OCOL_W-1:0]   col;
        logic [OROW_W-1:0]   row;
        logic [SAMPLE_W-1:0] sample;
        logic [SAMPLE_W-1:0] left;
    } t_stage;

endpackage

// ===== hw/rtl/hns_in_if.sv =====
interface hns_in_if;
    logic                          valid;
    logic                          ready;
    logic [hns_pkg::SAMPLE_W-1:0]  height_sample;

    modport source (output valid, output height_sample, input ready);
    modport sink   (input valid, input height_sample, output ready);
endinterface

// ===== hw/rtl/hns_out_if.sv =====
interface hns_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [hns_pkg::NRM_W-1:0] normal_x;
    logic [hns_pkg::NY_W-1:0]         normal_y;
    logic signed [hns_pkg::NRM_W-1:0] normal_z;
    logic [hns_pkg::OCOL_W-1:0]       out_column;
    logic [hns_pkg::OROW_W-1:0]       out_row;
    logic                             last_of_run;

    modport source (
        output valid, output normal_x, output normal_y, output normal_z,
        output out_column, output out_row, output last_of_run,
        input ready
    );
    modport sink (
        input valid, input normal_x, input normal_y, input normal_z,
        input out_column, input out_row, input last_of_run,
        output ready
    );
endinterface

// ===== hw/rtl/heightmap_normal_stencil_top.sv =====
// Height-map normal stencil. Height bytes enter in raster order, column fastest, one per
// clock while ready is high; the normal of the pixel one row above comes out as the
// unnormalized central-difference vector (2*(L-R)*s, 4, 2*(U-D)*s) in Q.8 for interior
// pixels and (0, 1, 0) for every border pixel. The first row of a frame gives no result,
// and each sample of the last row gives two (its own border pixel follows), so the output
// port bounds that row's rate; elsewhere it is one sample per cycle without output stalls,
// set by the single read port of each line buffer. Two line buffers of MAX_WIDTH bytes hold
// the previous and older rows; they need no clearing after reset.
// Change grid_width, grid_height or inverse_height_scale only while the block is idle.
module heightmap_normal_stencil_top #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    hns_in_if.sink                        i_in,
    hns_out_if.source                     o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [hns_pkg::PADDR_W-1:0]   paddr,
    input  logic [hns_pkg::PDATA_W-1:0]   pwdata,
    output logic [hns_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    hns_pkg::t_geom               geom;
    hns_pkg::t_stage              stage;
    logic [hns_pkg::SAMPLE_W-1:0] right, up;
    logic                         take;

    // Configuration registers
    hns_cfg #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready),
        .o_geom    (geom)
    );

    // Line buffers, counters and the neighbor window
    hns_lines #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_lines (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_geom  (geom),
        .i_take  (take),
        .o_stage (stage),
        .o_right (right),
        .o_up    (up)
    );

    // Normal arithmetic and result register
    hns_result u_result (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stage (stage),
        .i_right (right),
        .i_up    (up),
        .i_scale (geom.scale),
        .o_take  (take),
        .o_res   (o_out)
    );

endmodule

// ===== hw/rtl/hns_ram.sv =====
module hns_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and read ports; read returns the old contents on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/hns_cfg.sv =====
module hns_cfg #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic [hns_pkg::PADDR_W-1:0]   i_paddr,
    input  logic [hns_pkg::PDATA_W-1:0]   i_pwdata,
    output logic [hns_pkg::PDATA_W-1:0]   o_prdata,
    output logic                          o_pready,
    output hns_pkg::t_geom                o_geom
);

    logic [hns_pkg::GW_W-1:0] r_grid_width;
    logic [hns_pkg::GH_W-1:0] r_grid_height;
    hns_pkg::t_geom           r_geom;
    logic                     wr;
    logic [1:0]               idx;
    logic [hns_pkg::GW_W-1:0] n_w;
    logic [hns_pkg::GH_W-1:0] n_h;

    // Saturate the sizes to 2..MAX
    function automatic logic [hns_pkg::GW_W-1:0] clamp_w(input logic [hns_pkg::GW_W-1:0] v);
        if (v < hns_pkg::GW_W'(2)) begin
            return hns_pkg::GW_W'(2);
        end
        if (32'(v) > MAX_WIDTH) begin
            return hns_pkg::GW_W'(MAX_WIDTH);
        end
        return v;
    endfunction

    function automatic logic [hns_pkg::GH_W-1:0] clamp_h(input logic [hns_pkg::GH_W-1:0] v);
        if (v < hns_pkg::GH_W'(2)) begin
            return hns_pkg::GH_W'(2);
        end
        if (32'(v) > MAX_HEIGHT) begin
            return hns_pkg::GH_W'(MAX_HEIGHT);
        end
        return v;
    endfunction

    assign wr       = i_psel && i_penable && i_pwrite;
    assign idx      = i_paddr[3:2];
    assign o_pready = 1'b1;
    assign n_w      = clamp_w(i_pwdata[hns_pkg::GW_W-1:0]);
    assign n_h      = clamp_h(i_pwdata[hns_pkg::GH_W-1:0]);

    // Register writes; keep the raw value for readback and the clamped size for use
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= hns_pkg::GW_RESET;
            r_grid_height <= hns_pkg::GH_RESET;
            r_geom.w      <= clamp_w(hns_pkg::GW_RESET);
            r_geom.w_m1   <= clamp_w(hns_pkg::GW_RESET) - hns_pkg::GW_W'(1);
            r_geom.h      <= clamp_h(hns_pkg::GH_RESET);
            r_geom.h_m1   <= clamp_h(hns_pkg::GH_RESET) - hns_pkg::GH_W'(1);
            r_geom.scale  <= hns_pkg::SCALE_RESET;
        end else if (wr) begin
            unique case (idx)
                hns_pkg::REG_GRID_WIDTH: begin
                    r_grid_width <= i_pwdata[hns_pkg::GW_W-1:0];
                    r_geom.w     <= n_w;
                    r_geom.w_m1  <= n_w - hns_pkg::GW_W'(1);
                end
                hns_pkg::REG_GRID_HEIGHT: begin
                    r_grid_height <= i_pwdata[hns_pkg::GH_W-1:0];
                    r_geom.h      <= n_h;
                    r_geom.h_m1   <= n_h - hns_pkg::GH_W'(1);
                end
                hns_pkg::REG_INV_SCALE: begin
                    r_geom.scale <= i_pwdata[hns_pkg::SCALE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Readback mux
    always_comb begin
        unique case (idx)
            hns_pkg::REG_GRID_WIDTH:  o_prdata = hns_pkg::PDATA_W'(r_grid_width);
            hns_pkg::REG_GRID_HEIGHT: o_prdata = hns_pkg::PDATA_W'(r_grid_height);
            hns_pkg::REG_INV_SCALE:   o_prdata = hns_pkg::PDATA_W'(r_geom.scale);
            default:                  o_prdata = '0;
        endcase
    end

    assign o_geom = r_geom;

endmodule

// ===== hw/rtl/hns_lines.sv =====
module hns_lines #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    hns_in_if.sink                        i_in,
    input  hns_pkg::t_geom                i_geom,
    input  logic                          i_take,
    output hns_pkg::t_stage               o_stage,
    output logic [hns_pkg::SAMPLE_W-1:0]  o_right,
    output logic [hns_pkg::SAMPLE_W-1:0]  o_up
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int CXW = (CW + 1 > hns_pkg::GW_W) ? CW + 1 : hns_pkg::GW_W;
    localparam int RXW = (RW + 1 > hns_pkg::GH_W) ? RW + 1 : hns_pkg::GH_W;

    logic [CW-1:0]                r_col;
    logic [RW-1:0]                r_row;
    logic [CW-1:0]                n_col;
    logic [RW-1:0]                n_row;
    logic [hns_pkg::SAMPLE_W-1:0] r_left;
    hns_pkg::t_stage              r_stage;
    hns_pkg::t_stage              n_stage;

    logic                         accept;
    logic                         wrap_c;
    logic [CXW-1:0]               col_x, w_x, w_m1_x, c_x, c_inc;
    logic [RXW-1:0]               h_x, h_m1_x, row_a, r_x, r_inc;
    logic [CW-1:0]                c_addr, rd_addr;
    logic [hns_pkg::SAMPLE_W-1:0] prev_rd, older_rd;

    assign i_in.ready = !r_stage.valid || i_take;
    assign accept     = i_in.valid && i_in.ready;

    // Position of the incoming sample and the counters after it
    always_comb begin
        w_x    = CXW'(i_geom.w);
        w_m1_x = CXW'(i_geom.w_m1);
        h_x    = RXW'(i_geom.h);
        h_m1_x = RXW'(i_geom.h_m1);
        col_x  = CXW'(r_col);
        wrap_c = col_x >= w_x;
        c_x    = wrap_c ? '0 : col_x;
        row_a  = RXW'(r_row) + RXW'(wrap_c);
        r_x    = (row_a >= h_x) ? '0 : row_a;
        c_inc  = c_x + CXW'(1);
        r_inc  = r_x + RXW'(1);
        if (c_inc >= w_x) begin
            n_col = '0;
            n_row = (r_inc >= h_x) ? '0 : RW'(r_inc);
        end else begin
            n_col = CW'(c_inc);
            n_row = RW'(r_x);
        end
        c_addr  = CW'(c_x);
        rd_addr = accept ? n_col : c_addr;
    end

    // Classify the pixel one row up
    always_comb begin
        n_stage.valid    = 1'b1;
        n_stage.has_out  = r_x != '0;
        n_stage.last_row = r_x == h_m1_x;
        n_stage.interior = (c_x != '0) && (c_x < w_m1_x) && (r_x >= RXW'(2));
        n_stage.col      = hns_pkg::OCOL_W'(c_x);
        n_stage.row      = hns_pkg::OROW_W'(r_x - RXW'(1));
        n_stage.sample   = i_in.height_sample;
        n_stage.left     = r_left;
    end

    // Advance counters and the left neighbor on each request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_left <= prev_rd;
        end
    end

    // Hold the request until the result side takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else if (accept) begin
            r_stage <= n_stage;
        end else if (i_take) begin
            r_stage.valid <= 1'b0;
        end
    end

    // Previous row: read the column of the next request every cycle, write the new sample
    hns_ram #(
        .WIDTH (hns_pkg::SAMPLE_W),
        .DEPTH (MAX_WIDTH)
    ) u_prev (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (c_addr),
        .i_wdata (i_in.height_sample),
        .i_re    (1'b1),
        .i_raddr (rd_addr),
        .o_rdata (prev_rd)
    );

    // Older row: takes over the previous row's value at this column
    hns_ram #(
        .WIDTH (hns_pkg::SAMPLE_W),
        .DEPTH (MAX_WIDTH)
    ) u_older (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (c_addr),
        .i_wdata (prev_rd),
        .i_re    (accept),
        .i_raddr (c_addr),
        .o_rdata (older_rd)
    );

    assign o_stage = r_stage;
    assign o_right = prev_rd;
    assign o_up    = older_rd;

    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_stage.valid)
        else $error("accepted request did not reach the stage register");

    a_interior_has_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_stage.valid && r_stage.interior) |-> r_stage.has_out)
        else $error("interior pixel flagged on the first row");

endmodule

// ===== hw/rtl/hns_result.sv =====
module hns_result (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  hns_pkg::t_stage               i_stage,
    input  logic [hns_pkg::SAMPLE_W-1:0]  i_right,
    input  logic [hns_pkg::SAMPLE_W-1:0]  i_up,
    input  logic [hns_pkg::SCALE_W-1:0]   i_scale,
    output logic                          o_take,
    hns_out_if.source                     o_res
);

    logic                              r_o_valid;
    logic                              r_two;
    logic signed [hns_pkg::NRM_W-1:0]  r_nx, r_nz;
    logic [hns_pkg::NY_W-1:0]          r_ny;
    logic [hns_pkg::OCOL_W-1:0]        r_col;
    logic [hns_pkg::OROW_W-1:0]        r_row;
    logic                              r_last;

    logic                              free, load, pop;
    logic signed [hns_pkg::SAMPLE_W:0] dx, dz;
    logic signed [hns_pkg::NRM_W-1:0]  dx_w, dz_w, s_w, px, pz;

    assign pop    = r_o_valid && o_res.ready;
    assign free   = !r_o_valid || (o_res.ready && !r_two);
    assign o_take = i_stage.valid && (!i_stage.has_out || free);
    assign load   = o_take && i_stage.has_out;

    // Central differences scaled by the inverse height scale
    always_comb begin
        dx   = $signed({1'b0, i_stage.left}) - $signed({1'b0, i_right});
        dz   = $signed({1'b0, i_up}) - $signed({1'b0, i_stage.sample});
        dx_w = hns_pkg::NRM_W'(dx);
        dz_w = hns_pkg::NRM_W'(dz);
        s_w  = $signed(hns_pkg::NRM_W'(i_scale));
        px   = dx_w * s_w;
        pz   = dz_w * s_w;
    end

    // Output control: second result of the last row follows the first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
            r_two     <= 1'b0;
        end else if (load) begin
            r_o_valid <= 1'b1;
            r_two     <= i_stage.last_row;
        end else if (pop) begin
            if (r_two) begin
                r_two <= 1'b0;
            end else begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_nx   <= i_stage.interior ? (px <<< 1) : '0;
            r_nz   <= i_stage.interior ? (pz <<< 1) : '0;
            r_ny   <= i_stage.interior ? hns_pkg::NY_INTERIOR : hns_pkg::NY_BORDER;
            r_col  <= i_stage.col;
            r_row  <= i_stage.row;
            r_last <= !i_stage.last_row;
        end else if (pop && r_two) begin
            r_nx   <= '0;
            r_nz   <= '0;
            r_ny   <= hns_pkg::NY_BORDER;
            r_row  <= r_row + hns_pkg::OROW_W'(1);
            r_last <= 1'b1;
        end
    end

    assign o_res.valid       = r_o_valid;
    assign o_res.normal_x    = r_nx;
    assign o_res.normal_y    = r_ny;
    assign o_res.normal_z    = r_nz;
    assign o_res.out_column  = r_col;
    assign o_res.out_row     = r_row;
    assign o_res.last_of_run = r_last;

    a_two_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_two |-> r_o_valid)
        else $error("second result pending without a valid result");

    a_second_is_border: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && r_two) |=> (r_o_valid && r_last && r_ny == hns_pkg::NY_BORDER))
        else $error("last-row border result malformed");

endmodule
